### rtl/core/tdmm_pkg.sv
package tdmm_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_BITS   = ((DATA_WIDTH + 16) > 62) ? 62 : (DATA_WIDTH + 16);
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // alpha / beta mode codes
  localparam logic [1:0] MODE_ZERO  = 2'd0;
  localparam logic [1:0] MODE_PLUS  = 2'd1;
  localparam logic [1:0] MODE_MINUS = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 2'd2;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_val;
    logic signed [DATA_WIDTH-1:0] diag_val;
    logic signed [DATA_WIDTH-1:0] sub_val;
    logic signed [DATA_WIDTH-1:0] super_val;
    logic signed [DATA_WIDTH-1:0] b_in;
    logic                         last_row;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] b_out;
    logic                         column_end;
    logic                         run_last;
  } out_item_t;

endpackage

### rtl/core/tridiagonal_matmul_stream.sv
// Streaming tridiagonal matrix-vector product, b := alpha*op(A)*x + beta*b.
// in_*  : one request per row of a column (x, diagonal, sub, super, prior b,
//         last_row flag). Accepted when in_valid and in_ready are high.
// out_* : one updated b element per request, in row order. The result for a
//         row is produced once the following row has been accepted; a last row also
//         releases itself, after the held row if there is one.
// cfg_* : register writes (alpha mode, beta mode, transpose), always ready;
//         the user must write them only while the block is idle (unchecked).
// Pipeline: one row is accepted every cycle while in_ready is high. Its products
// are formed as it is accepted and registered; the next cycle scales, sums and
// saturates them and writes the results into an 8-entry output queue, and out_*
// shows the oldest queue entry. Throughput is set by the queue draining one
// result per cycle when out_ready is high: in_ready stays high only while the
// queue keeps room for two results from the request in the sum stage and two
// from the request being accepted.
// When the receiver stalls, the queue fills and in_ready falls; nothing is lost.
// Reset (synchronous, rst_n low) empties the queue and the pipeline, drops any
// held row and restores alpha = +1, beta = +1, no transpose.
module tridiagonal_matmul_stream (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tdmm_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tdmm_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tdmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdmm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tdmm_pkg::*;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] ACC_MAX_W =
    {{(PROD_W-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] ACC_MIN_W = ~ACC_MAX_W;
  localparam logic signed [ACC_BITS-1:0] OUT_MAX_A =
    {{(ACC_BITS-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] OUT_MIN_A = ~OUT_MAX_A;

  function automatic logic signed [ACC_BITS-1:0] clamp_wide(input logic signed [PROD_W-1:0] v);
    if (v > ACC_MAX_W) return ACC_MAX;
    else if (v < ACC_MIN_W) return ACC_MIN;
    else return v[ACC_BITS-1:0];
  endfunction

  // floor to the fixed-point format: arithmetic shift floors toward minus infinity
  function automatic logic signed [ACC_BITS-1:0] prod_fix(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p >>> FRAC_BITS;
    return clamp_wide(s);
  endfunction

  function automatic logic signed [ACC_BITS-1:0] neg_sat(input logic signed [ACC_BITS-1:0] v);
    if (v == ACC_MIN) return ACC_MAX;
    else return -v;
  endfunction

  function automatic logic signed [ACC_BITS-1:0] add_sat(input logic signed [ACC_BITS-1:0] a,
                                                         input logic signed [ACC_BITS-1:0] b);
    logic signed [ACC_BITS:0] s;
    s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
    if (s[ACC_BITS] != s[ACC_BITS-1]) return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
    else return s[ACC_BITS-1:0];
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_out(input logic signed [ACC_BITS-1:0] v);
    if (v > OUT_MAX_A) return OUT_MAX_A[DATA_WIDTH-1:0];
    else if (v < OUT_MIN_A) return OUT_MIN_A[DATA_WIDTH-1:0];
    else return v[DATA_WIDTH-1:0];
  endfunction

  // configuration
  logic [1:0] alpha_r;
  logic [1:0] beta_r;
  logic       transpose_r;

  // row held across requests (captured at accept)
  logic                         row_pending_r;
  logic signed [DATA_WIDTH-1:0] prev_x_r;
  logic signed [DATA_WIDTH-1:0] prev_lower_r;
  logic signed [DATA_WIDTH-1:0] prev_upper_r;

  // product stage
  logic                         va_r;
  logic                         pend_a_r;
  logic                         last_a_r;
  logic signed [DATA_WIDTH-1:0] b_a_r;
  logic signed [PROD_W-1:0]     p_dx_r;
  logic signed [PROD_W-1:0]     p_up_r;
  logic signed [PROD_W-1:0]     p_lo_r;

  // sum stage
  logic signed [ACC_BITS-1:0]   pending_sum_r;

  // output queue
  out_item_t               q_mem [QDEPTH];
  logic [QPTR_W-1:0]       wp_r;
  logic [QPTR_W-1:0]       rp_r;
  logic [QCNT_W-1:0]       cnt_r;

  logic in_fire;
  logic out_fire;
  logic [QCNT_W:0] room_need;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_fire  = out_valid && out_ready;
  assign out_data  = q_mem[rp_r];

  // an in-flight request may still push two results
  assign room_need = {1'b0, cnt_r} + (va_r ? (QCNT_W+1)'(2) : '0);
  assign in_ready  = (room_need <= (QCNT_W+1)'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= MODE_PLUS;
      beta_r      <= MODE_PLUS;
      transpose_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ALPHA:     alpha_r     <= cfg_data[1:0];
        CFG_BETA:      beta_r      <= cfg_data[1:0];
        CFG_TRANSPOSE: transpose_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r          <= 1'b0;
      row_pending_r <= 1'b0;
    end else begin
      va_r <= in_fire;
      if (in_fire) row_pending_r <= !in_data.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_a_r <= row_pending_r;
      last_a_r <= in_data.last_row;
      b_a_r    <= in_data.b_in;
      p_dx_r   <= PROD_W'(in_data.diag_val) * PROD_W'(in_data.x_val);
      p_up_r   <= PROD_W'(prev_upper_r) * PROD_W'(in_data.x_val);
      p_lo_r   <= PROD_W'(prev_lower_r) * PROD_W'(prev_x_r);
      if (!in_data.last_row) begin
        prev_x_r <= in_data.x_val;
        if (transpose_r) begin
          prev_upper_r <= in_data.sub_val;
          prev_lower_r <= in_data.super_val;
        end else begin
          prev_upper_r <= in_data.super_val;
          prev_lower_r <= in_data.sub_val;
        end
      end
    end
  end

  // sum stage
  logic signed [ACC_BITS-1:0] m_dx, m_up, m_lo;
  logic signed [ACC_BITS-1:0] b_ext, b_term, dx_term, up_term, lo_term;
  logic signed [ACC_BITS-1:0] acc0, acc1, done_sum;
  out_item_t r_done, r_last, r0;
  logic [1:0] push_n;

  always_comb begin
    m_dx  = prod_fix(p_dx_r);
    m_up  = prod_fix(p_up_r);
    m_lo  = prod_fix(p_lo_r);
    b_ext = ACC_BITS'(b_a_r);

    case (beta_r)
      MODE_ZERO:  b_term = '0;
      MODE_MINUS: b_term = neg_sat(b_ext);
      default:    b_term = b_ext;
    endcase

    case (alpha_r)
      MODE_PLUS: begin
        dx_term = m_dx;
        up_term = m_up;
        lo_term = m_lo;
      end
      MODE_MINUS: begin
        dx_term = neg_sat(m_dx);
        up_term = neg_sat(m_up);
        lo_term = neg_sat(m_lo);
      end
      default: begin
        dx_term = '0;
        up_term = '0;
        lo_term = '0;
      end
    endcase

    acc0     = add_sat(b_term, dx_term);
    acc1     = pend_a_r ? add_sat(acc0, lo_term) : acc0;
    done_sum = add_sat(pending_sum_r, up_term);

    r_done.b_out      = sat_out(done_sum);
    r_done.column_end = 1'b0;
    r_done.run_last   = !last_a_r;

    r_last.b_out      = sat_out(acc1);
    r_last.column_end = 1'b1;
    r_last.run_last   = 1'b1;

    r0     = pend_a_r ? r_done : r_last;
    push_n = va_r ? ({1'b0, pend_a_r} + {1'b0, last_a_r}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (va_r) pending_sum_r <= last_a_r ? '0 : acc1;
    if (push_n != 2'd0) q_mem[wp_r] <= r0;
    if (push_n == 2'd2) q_mem[wp_r + QPTR_W'(1)] <= r_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + QPTR_W'(push_n);
      if (out_fire) rp_r <= rp_r + QPTR_W'(1);
      cnt_r <= cnt_r + QCNT_W'(push_n) - (out_fire ? QCNT_W'(1) : '0);
    end
  end

endmodule
